### rtl/magnetometer_calibrate_heading_core_defines.svh
// ---------------------------------------------------------------------------
// magnetometer_calibrate_heading_core_defines
// assertion macros for the heading core
// ---------------------------------------------------------------------------
`ifndef MAGNETOMETER_CALIBRATE_HEADING_CORE_DEFINES_SVH
`define MAGNETOMETER_CALIBRATE_HEADING_CORE_DEFINES_SVH
// concurrent assertion on clk_i, off while reset is low
`define MCH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition that must never hold on clk_i, off while reset is low
`define MCH_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

### rtl/mch_pkg.sv
// ---------------------------------------------------------------------------
// mch_pkg
// shared widths, constants and the arctangent table of the heading core
// ---------------------------------------------------------------------------
`default_nettype none
package mch_pkg;
  localparam int RawW     = 16;
  localparam int CalW     = 22;
  localparam int HeadW    = 15;
  localparam int RowW     = 48;
  localparam int CfgIdxW  = 3;
  localparam int Stages   = 16;
  localparam int CalcW    = 32;
  localparam int AngW     = 32;
  localparam int DiffW    = 17;
  localparam int ProdW    = 33;
  localparam int SumW     = 35;
  localparam logic [HeadW-1:0] HeadTurn = 15'd23040;
  localparam logic signed [CalW-1:0] CalMax = 22'sd2097151;
  localparam logic signed [CalW-1:0] CalMin = -22'sd2097152;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BIAS_X = 3'd0, REG_BIAS_Y = 3'd1, REG_BIAS_Z = 3'd2,
    REG_ROW_X = 3'd3, REG_ROW_Y = 3'd4, REG_ROW_Z = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [CalW-1:0] x;
    logic signed [CalW-1:0] y;
    logic signed [CalW-1:0] z;
  } cal_vec_t;

  function automatic logic [AngW-1:0] atan_entry(input int i);
    logic [AngW-1:0] t;
    case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

### rtl/mch_axis_lane.sv
// ---------------------------------------------------------------------------
// mch_axis_lane
// one calibration lane: row times corrected vector, shift and saturate
// ---------------------------------------------------------------------------
`default_nettype none
module mch_axis_lane (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic signed [mch_pkg::DiffW-1:0] d0_i,
  input  wire logic signed [mch_pkg::DiffW-1:0] d1_i,
  input  wire logic signed [mch_pkg::DiffW-1:0] d2_i,
  input  wire logic [mch_pkg::RowW-1:0]        row_i,
  output logic signed [mch_pkg::CalW-1:0]      cal_o
);
  import mch_pkg::*;
  logic signed [ProdW-1:0] p0_q, p1_q, p2_q;
  logic signed [SumW-1:0]  sum, shifted;
  logic signed [CalW-1:0]  cal_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= ProdW'(d0_i) * ProdW'($signed(row_i[15:0]));
      p1_q <= ProdW'(d1_i) * ProdW'($signed(row_i[31:16]));
      p2_q <= ProdW'(d2_i) * ProdW'($signed(row_i[47:32]));
    end
  end

  always_comb begin
    sum = SumW'(p0_q) + SumW'(p1_q) + SumW'(p2_q);
    shifted = sum >>> 12;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (shifted > SumW'(CalMax)) cal_q <= CalMax;
      else if (shifted < SumW'(CalMin)) cal_q <= CalMin;
      else cal_q <= shifted[CalW-1:0];
    end
  end
  assign cal_o = cal_q;
endmodule
`default_nettype wire

### rtl/mch_cordic.sv
// ---------------------------------------------------------------------------
// mch_cordic
// pipelined vectoring cordic, heading in 1/64 degree
// ---------------------------------------------------------------------------
`default_nettype none
module mch_cordic (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire mch_pkg::cal_vec_t             vec_i,
  output mch_pkg::cal_vec_t                  vec_o,
  output logic [mch_pkg::HeadW-1:0]          heading_o
);
  import mch_pkg::*;
  logic signed [CalcW-1:0] x_q [Stages+1];
  logic signed [CalcW-1:0] y_q [Stages+1];
  logic [AngW-1:0]         a_q [Stages+1];
  logic                    z_q [Stages+1];
  cal_vec_t                v_q [Stages+1];
  logic [HeadW-1:0]        head_q;
  logic signed [CalcW-1:0] x0, y0;
  logic [AngW+HeadW-1:0]   prod;
  logic [HeadW:0]          h;

  always_comb begin
    x0 = CalcW'(vec_i.x) <<< 8;
    y0 = CalcW'(vec_i.y) <<< 8;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0] <= (vec_i.x == '0) && (vec_i.y == '0);
      v_q[0] <= vec_i;
      if (x0 < 0) begin
        x_q[0] <= -x0;
        y_q[0] <= -y0;
        a_q[0] <= 32'h80000000;
      end else begin
        x_q[0] <= x0;
        y_q[0] <= y0;
        a_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[i+1] <= z_q[i];
        v_q[i+1] <= v_q[i];
        if (!y_q[i][CalcW-1]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          a_q[i+1] <= a_q[i] + atan_entry(i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          a_q[i+1] <= a_q[i] - atan_entry(i);
        end
      end
    end
  end

  always_comb begin
    prod = (AngW+HeadW)'(a_q[Stages]) * (AngW+HeadW)'(HeadTurn)
         + (AngW+HeadW)'(33'h080000000);
    h = prod[AngW+HeadW-1:AngW-1] >> 1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_o <= v_q[Stages];
      if (z_q[Stages] || h[HeadW-1:0] >= HeadTurn || h[HeadW]) head_q <= '0;
      else head_q <= h[HeadW-1:0];
    end
  end
  assign heading_o = head_q;
endmodule
`default_nettype wire

### rtl/magnetometer_calibrate_heading_core.sv
// ---------------------------------------------------------------------------
// magnetometer_calibrate_heading_core
// hard/soft iron calibration with cordic heading
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one raw sample per transaction, m_axis one result.
//   configuration is written on cfg_we_i / cfg_idx_i / cfg_data_i while idle.
//   the datapath is a fixed pipeline of 21 stages: 3 lanes of row multiply
//   (products, then sum/shift/saturate), a bias stage, 17 cordic stages and
//   one heading scale stage.
//   throughput one transaction per cycle; the pipeline advances as a whole
//   whenever the output stage is empty or being taken.
//   when a result waits and m_axis_tready is low the whole pipeline holds and
//   s_axis_tready drops with it, so nothing is lost.
//   reset empties the pipeline and loads zero bias and the identity matrix.
`default_nettype none
`include "magnetometer_calibrate_heading_core_defines.svh"
module magnetometer_calibrate_heading_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [47:0]                     s_axis_tdata,  // raw_x, raw_y, raw_z
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [87:0]                          m_axis_tdata,  // cal_x, cal_y, cal_z, heading
  input  wire logic                            cfg_we_i,
  input  wire logic [mch_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [mch_pkg::RowW-1:0]        cfg_data_i
);
  import mch_pkg::*;
  localparam int Depth = Stages + 5;

  logic signed [RawW-1:0] bias_x_q, bias_y_q, bias_z_q;
  logic [RowW-1:0] row_x_q, row_y_q, row_z_q;
  logic [Depth-1:0] vld_q;
  logic en;
  logic signed [DiffW-1:0] d0_q, d1_q, d2_q;
  cal_vec_t cal, cal_out;
  logic [HeadW-1:0] heading;

  assign en = !vld_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_x_q <= '0; bias_y_q <= '0; bias_z_q <= '0;
      row_x_q <= 48'd4096;
      row_y_q <= 48'd4096 << 16;
      row_z_q <= 48'd4096 << 32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BIAS_X: bias_x_q <= cfg_data_i[RawW-1:0];
        REG_BIAS_Y: bias_y_q <= cfg_data_i[RawW-1:0];
        REG_BIAS_Z: bias_z_q <= cfg_data_i[RawW-1:0];
        REG_ROW_X:  row_x_q <= cfg_data_i;
        REG_ROW_Y:  row_y_q <= cfg_data_i;
        REG_ROW_Z:  row_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_q <= DiffW'($signed(s_axis_tdata[15:0])) - DiffW'(bias_x_q);
      d1_q <= DiffW'($signed(s_axis_tdata[31:16])) - DiffW'(bias_y_q);
      d2_q <= DiffW'($signed(s_axis_tdata[47:32])) - DiffW'(bias_z_q);
    end
  end

  mch_axis_lane u_lane_x (.clk_i, .en_i(en), .d0_i(d0_q), .d1_i(d1_q), .d2_i(d2_q),
                          .row_i(row_x_q), .cal_o(cal.x));
  mch_axis_lane u_lane_y (.clk_i, .en_i(en), .d0_i(d0_q), .d1_i(d1_q), .d2_i(d2_q),
                          .row_i(row_y_q), .cal_o(cal.y));
  mch_axis_lane u_lane_z (.clk_i, .en_i(en), .d0_i(d0_q), .d1_i(d1_q), .d2_i(d2_q),
                          .row_i(row_z_q), .cal_o(cal.z));

  mch_cordic u_cordic (.clk_i, .en_i(en), .vec_i(cal), .vec_o(cal_out),
                       .heading_o(heading));

  assign m_axis_tdata = {7'd0, heading, cal_out.z, cal_out.y, cal_out.x};

  `MCH_ASSERT(a_head_range, m_axis_tvalid |-> m_axis_tdata[80:66] < HeadTurn, "heading range")
  `MCH_ASSERT(a_hold, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped")
  `MCH_NEVER(a_ready, m_axis_tvalid && !m_axis_tready && s_axis_tready, "ready while full")
endmodule
`default_nettype wire

### dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// stream test of the magnetometer calibration and heading core: a scoreboard
// predicts bias subtraction, soft-iron matrix, saturation and cordic heading
// for every accepted sample and checks each result transaction field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import mch_pkg::*;

  typedef struct {
    logic [21:0] cx;
    logic [21:0] cy;
    logic [21:0] cz;
    logic [14:0] hd;
  } cal_result_t;

  class cal_scoreboard;
    logic [15:0] bias[3];
    logic [47:0] rows[3];
    cal_result_t pending[$];
    int unsigned errors;

    function new();
      bias = '{16'd0, 16'd0, 16'd0};
      rows = '{48'd4096, 48'd4096 << 16, 48'd4096 << 32};
      errors = 0;
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    function void write_reg(logic [2:0] idx, logic [47:0] val);
      if (idx <= REG_BIAS_Z) bias[idx] = val[15:0];
      else if (idx <= REG_ROW_Z) rows[idx - REG_ROW_X] = val;
    endfunction

    function longint row_sum(logic [47:0] row, longint d[3]);
      longint s;
      s = 0;
      for (int c = 0; c < 3; c++) s += longint'($signed(row[16*c +: 16])) * d[c];
      s = s >>> 12;
      if (s > 2097151) s = 2097151;
      if (s < -2097152) s = -2097152;
      return s;
    endfunction

    function logic [14:0] heading_of(longint cx, longint cy);
      longint x, y, nx;
      logic [31:0] ang;
      logic [63:0] h;
      if (cx == 0 && cy == 0) return '0;
      x = cx * 256;
      y = cy * 256;
      ang = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        ang = 32'h8000_0000;
      end
      for (int i = 0; i < Stages && i < 24; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          ang += atan_entry(i);
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          ang -= atan_entry(i);
        end
        x = nx;
      end
      h = (64'(ang) * 64'd23040 + 64'h8000_0000) >> 32;
      if (h >= 23040) h = 0;
      return h[14:0];
    endfunction

    function void note_sample(logic [47:0] raw);
      longint d[3];
      longint c[3];
      cal_result_t r;
      for (int a = 0; a < 3; a++)
        d[a] = longint'($signed(raw[16*a +: 16])) - longint'($signed(bias[a]));
      for (int a = 0; a < 3; a++) c[a] = row_sum(rows[a], d);
      r.cx = c[0][21:0];
      r.cy = c[1][21:0];
      r.cz = c[2][21:0];
      r.hd = heading_of(c[0], c[1]);
      pending.push_back(r);
    endfunction

    task check_result(logic [87:0] data);
      cal_result_t w;
      if (pending.size() == 0) begin
        report("unexpected result", data[31:0], 0);
        return;
      end
      w = pending.pop_front();
      if (data[21:0] !== w.cx) report("cal_x", data[21:0], w.cx);
      if (data[43:22] !== w.cy) report("cal_y", data[43:22], w.cy);
      if (data[65:44] !== w.cz) report("cal_z", data[65:44], w.cz);
      if (data[80:66] !== w.hd) report("heading", data[80:66], w.hd);
      if (data[87:81] !== '0) report("pad", data[87:81], 0);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [87:0] m_axis_tdata;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [RowW-1:0] cfg_data_i = '0;

  cal_scoreboard sb = new();
  bit hold_sink = 0;
  bit sink_quiet = 0;
  longint unsigned cycles = 0;

  always #2 clk_i = ~clk_i;

  magnetometer_calibrate_heading_core i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 0;
        repeat (120) @(negedge clk_i);
        hold_sink = 0;
      end
      n = sink_quiet ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14));
      if (n > 0) begin
        m_axis_tready <= 0;
        repeat (n - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      m_axis_tready <= 1;
    end
  end

  task automatic write_cfg(input reg_idx_e idx, input logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic send_sample(input logic [47:0] raw, input bit gaps);
    int n;
    n = gaps && ($urandom_range(0, 3) != 0) ? $urandom_range(0, 14) : 0;
    if (n > 0) begin
      s_axis_tvalid <= 0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= raw;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [47:0] rnd_row();
    logic [47:0] r;
    for (int c = 0; c < 3; c++)
      case ($urandom_range(0, 3))
        0: r[16*c +: 16] = 16'(int'($urandom_range(0, 8192)) - 4096);
        1: r[16*c +: 16] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        default: r[16*c +: 16] = 16'($urandom());
      endcase
    return r;
  endfunction

  task automatic random_phase(input int count, input bit gaps);
    for (int k = 0; k < count; k++) send_sample({rnd16(), rnd16(), rnd16()}, gaps);
    s_axis_tvalid <= 0;
  endtask

  initial begin
    logic [15:0] ex[4];
    ex = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: identity, extremes, zero vector, axes and quadrants
    for (int a = 0; a < 4; a++)
      for (int b = 0; b < 4; b++) send_sample({ex[(a + b) % 4], ex[b], ex[a]}, 0);
    send_sample({16'd5, 16'd0, 16'd100}, 0);
    send_sample({16'd5, 16'd100, 16'd0}, 0);
    send_sample({16'd5, 16'hff9c, 16'd0}, 0);
    send_sample({16'd5, 16'd0, 16'hff9c}, 0);
    send_sample({16'd1, 16'd1, 16'hffff}, 0);
    s_axis_tvalid <= 0;
    wait_drained();

    // saturating matrix, extreme biases, with an ignored write index
    write_cfg(REG_BIAS_X, 48'h7fff);
    write_cfg(REG_BIAS_Y, 48'hffff_ffff_8000);
    write_cfg(REG_BIAS_Z, 48'h7fff);
    write_cfg(REG_ROW_X, {16'h7fff, 16'h7fff, 16'h7fff});
    write_cfg(REG_ROW_Y, {16'h8000, 16'h8000, 16'h8000});
    write_cfg(REG_ROW_Z, {16'h8000, 16'h7fff, 16'h0000});
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= 3'd7;
    cfg_data_i <= '1;
    @(negedge clk_i);
    cfg_we_i <= 0;
    for (int a = 0; a < 4; a++) send_sample({ex[a], ex[3 - a], ex[a]}, 0);
    random_phase(40, 1);
    wait_drained();

    // long receiver hold-off while samples keep coming back to back
    hold_sink = 1;
    random_phase(80, 0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      write_cfg(REG_BIAS_X, {32'($urandom()), rnd16()});
      write_cfg(REG_BIAS_Y, {32'($urandom()), rnd16()});
      write_cfg(REG_BIAS_Z, {32'($urandom()), rnd16()});
      write_cfg(REG_ROW_X, rnd_row());
      write_cfg(REG_ROW_Y, rnd_row());
      write_cfg(REG_ROW_Z, rnd_row());
      sink_quiet = (p == 1);
      random_phase(90, 1);
      wait_drained();
    end
    sink_quiet = 0;

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/mch_pkg.sv
rtl/mch_axis_lane.sv
rtl/mch_cordic.sv
rtl/magnetometer_calibrate_heading_core.sv
dv/testbench.sv
